>>> src/axis_angle_vector_rotation_defines.svh
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_defines
// assertion macros shared by the rotation block
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_VECTOR_ROTATION_DEFINES_SVH
`define AXIS_ANGLE_VECTOR_ROTATION_DEFINES_SVH

// condition that holds at every edge out of reset
`define AAVR_HOLDS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define AAVR_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg
// types, constants and helpers of the axis-angle vector rotation block
// ----------------------------------------------------------------------------
`default_nettype none

package aavr_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 24;
	localparam int unsigned XW = 34;
	localparam int unsigned ZW = 33;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned PTR_W = $clog2(QDEPTH);
	localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

	localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [XW-1:0] ONE_Q30 = 34'sd1073741824;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic [31:0]        turn_angle;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} out_beat_t;

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		quad_t              quad;
		logic signed [31:0] zang;
	} q_item_t;

	function automatic logic [31:0] atan_turn(input int unsigned i);
		logic [31:0] r;
		case (i)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			24: r = 32'd41;
			25: r = 32'd20;
			26: r = 32'd10;
			27: r = 32'd5;
			28: r = 32'd3;
			29: r = 32'd1;
			30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// q30 product back to q30, round half away from zero
	function automatic logic signed [37:0] rnd_q30(input logic signed [67:0] p);
		logic signed [67:0] b;
		logic signed [67:0] s;
		b = p[67] ? 68'sd536870911 : 68'sd536870912;
		s = (p + b) >>> 30;
		return s[37:0];
	endfunction

endpackage

`default_nettype wire

>>> src/aavr_stream_if.sv
// ----------------------------------------------------------------------------
// aavr_stream_if
// valid/ready channel carrying one beat of type T
// ----------------------------------------------------------------------------
`default_nettype none

interface aavr_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/aavr_front.sv
// ----------------------------------------------------------------------------
// aavr_front
// accepts input beats and splits the angle into quadrant and residual
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_front (
	input  logic              clk,
	input  logic              arst_n,
	aavr_stream_if.sink       request,
	output aavr_pkg::q_item_t item,
	output logic              item_valid,
	input  logic              item_ready
);
	import aavr_pkg::*;

	logic        valid_q;
	q_item_t     item_q;
	logic [31:0] shifted;
	logic [1:0]  qbits;
	logic [31:0] resid;

	assign request.ready = !valid_q || item_ready;
	assign item_valid = valid_q;
	assign item = item_q;

	always_comb begin
		shifted = request.data.turn_angle + 32'h2000_0000;
		qbits = shifted[31:30];
		resid = request.data.turn_angle - {qbits, 30'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (request.ready) begin
			valid_q <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.ready && request.valid) begin
			item_q.vec_x <= request.data.vec_x;
			item_q.vec_y <= request.data.vec_y;
			item_q.vec_z <= request.data.vec_z;
			item_q.axis_x <= request.data.axis_x;
			item_q.axis_y <= request.data.axis_y;
			item_q.axis_z <= request.data.axis_z;
			item_q.quad <= quad_t'(qbits);
			item_q.zang <= signed'(resid);
		end
	end

endmodule

`default_nettype wire

>>> src/aavr_fifo.sv
// ----------------------------------------------------------------------------
// aavr_fifo
// short queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

`include "axis_angle_vector_rotation_defines.svh"

module aavr_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  aavr_pkg::q_item_t push_data,
	input  logic              push_valid,
	output logic              push_ready,
	output aavr_pkg::q_item_t pop_data,
	output logic              pop_valid,
	input  logic              pop_ready
);
	import aavr_pkg::*;

	q_item_t          mem [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = cnt_q != CNT_W'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_ready && pop_valid;
	assign pop_data = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_data;
	end

	`AAVR_HOLDS(a_cnt_range, cnt_q <= CNT_W'(QDEPTH), "queue count beyond depth")
	`AAVR_NEXT(a_push_fills, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "push lost")
	`AAVR_NEXT(a_pop_drains, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "pop lost")

endmodule

`default_nettype wire

>>> src/aavr_cordic.sv
// ----------------------------------------------------------------------------
// aavr_cordic
// pipelined cordic, one micro-rotation a stage, then clamp and quadrant fix
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_cordic #(
	parameter int unsigned STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  aavr_pkg::quad_t    quad,
	input  logic signed [31:0] zang,
	output logic signed [31:0] cos_v,
	output logic signed [31:0] sin_v
);
	import aavr_pkg::*;

	logic signed [XW-1:0] x_s [STEPS];
	logic signed [XW-1:0] y_s [STEPS];
	logic signed [ZW-1:0] z_s [STEPS];
	quad_t                q_s [STEPS];
	logic signed [31:0]   cos_q;
	logic signed [31:0]   sin_q;
	logic signed [31:0]   xc;
	logic signed [31:0]   yc;

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic signed [XW-1:0] xi;
		logic signed [XW-1:0] yi;
		logic signed [ZW-1:0] zi;
		quad_t                qi;
		logic signed [ZW-1:0] at;

		if (g == 0) begin : g_first
			assign xi = GAIN_Q30;
			assign yi = '0;
			assign zi = ZW'(zang);
			assign qi = quad;
		end else begin : g_next
			assign xi = x_s[g-1];
			assign yi = y_s[g-1];
			assign zi = z_s[g-1];
			assign qi = q_s[g-1];
		end

		assign at = ZW'(atan_turn(g));

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[g] <= qi;
				if (!zi[ZW-1]) begin
					x_s[g] <= xi - (yi >>> g);
					y_s[g] <= yi + (xi >>> g);
					z_s[g] <= zi - at;
				end else begin
					x_s[g] <= xi + (yi >>> g);
					y_s[g] <= yi - (xi >>> g);
					z_s[g] <= zi + at;
				end
			end
		end
	end

	function automatic logic signed [31:0] clamp1(input logic signed [XW-1:0] v);
		logic signed [31:0] r;
		if (v > ONE_Q30) r = 32'sd1073741824;
		else if (v < -ONE_Q30) r = -32'sd1073741824;
		else r = v[31:0];
		return r;
	endfunction

	assign xc = clamp1(x_s[STEPS-1]);
	assign yc = clamp1(y_s[STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (q_s[STEPS-1])
				QUAD_0: begin
					cos_q <= xc;
					sin_q <= yc;
				end
				QUAD_1: begin
					cos_q <= -yc;
					sin_q <= xc;
				end
				QUAD_2: begin
					cos_q <= -xc;
					sin_q <= -yc;
				end
				QUAD_3: begin
					cos_q <= yc;
					sin_q <= -xc;
				end
			endcase
		end
	end

	assign cos_v = cos_q;
	assign sin_v = sin_q;

endmodule

`default_nettype wire

>>> src/aavr_back.sv
// ----------------------------------------------------------------------------
// aavr_back
// sine/cosine, rotation matrix terms, matrix-vector product and saturation
// ----------------------------------------------------------------------------
`default_nettype none

module aavr_back #(
	parameter int unsigned STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  aavr_pkg::q_item_t head,
	input  logic              head_valid,
	output logic              pop,
	aavr_stream_if.source     response
);
	import aavr_pkg::*;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [33:0] pxx;
		logic signed [33:0] pyy;
		logic signed [33:0] pzz;
		logic signed [33:0] pxy;
		logic signed [33:0] pxz;
		logic signed [33:0] pyz;
	} carry_t;

	logic               en;
	carry_t             entry;
	carry_t             dl [STEPS+1];
	logic               vl [STEPS+1];
	logic signed [31:0] cos_v;
	logic signed [31:0] sin_v;
	carry_t             cur;

	logic signed [67:0] e_p [6];

	logic signed [32:0] omc;
	logic signed [67:0] t_p [9];
	logic signed [34:0] t_s2 [6];
	logic signed [32:0] sn_s2 [3];
	logic signed [31:0] c_s2;
	logic signed [31:0] v_s2 [3];
	logic               vld_s2;

	logic signed [35:0] m_d [9];
	logic signed [35:0] m_s3 [9];
	logic signed [31:0] v_s3 [3];
	logic               vld_s3;

	logic signed [51:0] hi_s4 [9];
	logic signed [48:0] lo_s4 [9];
	logic               vld_s4;

	logic signed [53:0] hs_s5 [3];
	logic signed [50:0] ls_s5 [3];
	logic               vld_s5;

	logic signed [70:0] acc [3];
	logic signed [40:0] rr [3];
	logic signed [31:0] sat [3];
	logic               out_valid_q;
	out_beat_t          rot_q;

	assign en = !out_valid_q || response.ready;
	assign pop = en && head_valid;

	aavr_cordic #(.STEPS(STEPS)) u_cordic (
		.clk   (clk),
		.en    (en),
		.quad  (head.quad),
		.zang  (head.zang),
		.cos_v (cos_v),
		.sin_v (sin_v)
	);

	// axis outer products
	always_comb begin
		e_p[0] = head.axis_x * head.axis_x;
		e_p[1] = head.axis_y * head.axis_y;
		e_p[2] = head.axis_z * head.axis_z;
		e_p[3] = head.axis_x * head.axis_y;
		e_p[4] = head.axis_x * head.axis_z;
		e_p[5] = head.axis_y * head.axis_z;
		entry.vx = head.vec_x;
		entry.vy = head.vec_y;
		entry.vz = head.vec_z;
		entry.ax = head.axis_x;
		entry.ay = head.axis_y;
		entry.az = head.axis_z;
		entry.pxx = 34'(rnd_q30(e_p[0]));
		entry.pyy = 34'(rnd_q30(e_p[1]));
		entry.pzz = 34'(rnd_q30(e_p[2]));
		entry.pxy = 34'(rnd_q30(e_p[3]));
		entry.pxz = 34'(rnd_q30(e_p[4]));
		entry.pyz = 34'(rnd_q30(e_p[5]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dl[0] <= entry;
			for (int k = 1; k <= STEPS; k++) dl[k] <= dl[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) vl[k] <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vl[0] <= head_valid;
			for (int k = 1; k <= STEPS; k++) vl[k] <= vl[k-1];
			vld_s2 <= vl[STEPS];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			out_valid_q <= vld_s5;
		end
	end

	// scale by (1 - cos) and sine
	assign cur = dl[STEPS];

	always_comb begin
		omc = 33'sd1073741824 - 33'(cos_v);
		t_p[0] = cur.pxx * omc;
		t_p[1] = cur.pyy * omc;
		t_p[2] = cur.pzz * omc;
		t_p[3] = cur.pxy * omc;
		t_p[4] = cur.pxz * omc;
		t_p[5] = cur.pyz * omc;
		t_p[6] = cur.ax * sin_v;
		t_p[7] = cur.ay * sin_v;
		t_p[8] = cur.az * sin_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 6; k++) t_s2[k] <= 35'(rnd_q30(t_p[k]));
			for (int k = 0; k < 3; k++) sn_s2[k] <= 33'(rnd_q30(t_p[k+6]));
			c_s2 <= cos_v;
			v_s2[0] <= cur.vx;
			v_s2[1] <= cur.vy;
			v_s2[2] <= cur.vz;
		end
	end

	// matrix terms, order xx xy xz / yx yy yz / zx zy zz
	always_comb begin
		m_d[0] = 36'(t_s2[0]) + 36'(c_s2);
		m_d[1] = 36'(t_s2[3]) - 36'(sn_s2[2]);
		m_d[2] = 36'(t_s2[4]) + 36'(sn_s2[1]);
		m_d[3] = 36'(t_s2[3]) + 36'(sn_s2[2]);
		m_d[4] = 36'(t_s2[1]) + 36'(c_s2);
		m_d[5] = 36'(t_s2[5]) - 36'(sn_s2[0]);
		m_d[6] = 36'(t_s2[4]) - 36'(sn_s2[1]);
		m_d[7] = 36'(t_s2[5]) + 36'(sn_s2[0]);
		m_d[8] = 36'(t_s2[2]) + 36'(c_s2);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) m_s3[k] <= m_d[k];
			for (int k = 0; k < 3; k++) v_s3[k] <= v_s2[k];
		end
	end

	// split partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				hi_s4[k] <= v_s3[k % 3] * $signed(m_s3[k][35:16]);
				lo_s4[k] <= v_s3[k % 3] * $signed({1'b0, m_s3[k][15:0]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				hs_s5[j] <= 54'(hi_s4[3*j]) + 54'(hi_s4[3*j+1]) + 54'(hi_s4[3*j+2]);
				ls_s5[j] <= 51'(lo_s4[3*j]) + 51'(lo_s4[3*j+1]) + 51'(lo_s4[3*j+2]);
			end
		end
	end

	// round half up and saturate
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			acc[j] = (71'(hs_s5[j]) <<< 16) + 71'(ls_s5[j]) + 71'sd536870912;
			rr[j] = 41'(acc[j] >>> 30);
			if (rr[j] > 41'sd2147483647) sat[j] = 32'sh7fff_ffff;
			else if (rr[j] < -41'sd2147483648) sat[j] = 32'sh8000_0000;
			else sat[j] = rr[j][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_q.rot_x <= sat[0];
			rot_q.rot_y <= sat[1];
			rot_q.rot_z <= sat[2];
		end
	end

	assign response.valid = out_valid_q;
	assign response.data = rot_q;

endmodule

`default_nettype wire

>>> src/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation
// rotates a q16.16 vector about a q2.30 axis by a fraction of a full turn
// ----------------------------------------------------------------------------
// request beats carry vec_x/y/z, axis_x/y/z and turn_angle; response beats
// carry rot_x/y/z, saturated to the q16.16 range. one response per request,
// in order.
// a front register splits the angle into quadrant and residual and writes a
// four-deep queue; the back pipeline runs a cordic with one stage per
// micro-rotation, then matrix terms, split products, row sums and the
// rounded, saturated output register.
// throughput: one beat per cycle while the receiver takes responses.
// when the receiver stalls the back pipeline holds, the queue fills, and then
// request.ready drops. reset clears all valid flags and queue pointers; no
// pass over any storage follows.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_angle_vector_rotation #(
	parameter int unsigned CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	aavr_stream_if.sink   request,
	aavr_stream_if.source response
);
	import aavr_pkg::*;

	q_item_t f_item;
	logic    f_valid;
	logic    f_ready;
	q_item_t h_item;
	logic    h_valid;
	logic    h_pop;

	aavr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.request    (request),
		.item       (f_item),
		.item_valid (f_valid),
		.item_ready (f_ready)
	);

	aavr_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (f_item),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_data   (h_item),
		.pop_valid  (h_valid),
		.pop_ready  (h_pop)
	);

	aavr_back #(.STEPS(CORDIC_STEPS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (h_item),
		.head_valid (h_valid),
		.pop        (h_pop),
		.response   (response)
	);

endmodule

`default_nettype wire
